// ===== src/ffba_pkg.sv =====
// Shared types and codes for the first-fit block bitmap allocator.
// No dependencies; ffba_word_scan, ffba_blk_div and the top module import this package.
`default_nettype none

package ffba_pkg;

    localparam int ADDR_W = 48;
    localparam int CNT_W  = 11;
    localparam int WORD_W = 32;
    localparam int POS_W  = 5;

    // request codes
    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_FREE  = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    // result codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_REJECT   = 2'd2;

    // configuration register indexes
    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_BLOCKS = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_RMW,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] carry;
    } scan_res_t;

    typedef struct packed {
        logic             done;
        logic             in_range;
        logic             exact;
        logic [CNT_W-1:0] quot;
    } div_res_t;

endpackage

`default_nettype wire

// ===== src/ffba_map_mem.sv =====
// Block-used bitmap storage: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module ffba_map_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/ffba_word_scan.sv =====
// One 32-bit map word checked for the first free run reaching the requested length.
// Depends on ffba_pkg.
`default_nettype none

module ffba_word_scan
    import ffba_pkg::*;
(
    input  wire logic [WORD_W-1:0] word,
    input  wire logic [CNT_W-1:0]  carry,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [5:0]        limit,
    output scan_res_t              res
);

    logic [CNT_W:0]      run [WORD_W];
    logic [WORD_W-1:0]   hit_vec;
    logic [WORD_W-1:0]   below;
    logic [POS_W-1:0]    first_pos;

    // index of highest set bit
    function automatic logic [POS_W-1:0] msb_pos(input logic [WORD_W-1:0] v);
        logic [POS_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (v[i])
            begin
                r = POS_W'(i);
            end
        end
        return r;
    endfunction

    // free run ending at each bit, including the run carried from lower words
    always_comb
    begin
        below = '0;
        for (int p = 0; p < WORD_W; p++)
        begin
            below = word & ({WORD_W{1'b1}} >> (WORD_W - 1 - p));
            if (below == '0)
            begin
                run[p] = (CNT_W+1)'(carry) + (CNT_W+1)'(p + 1);
            end
            else
            begin
                run[p] = (CNT_W+1)'(p) - (CNT_W+1)'(msb_pos(below));
            end
            hit_vec[p] = (6'(p) < limit) && (run[p] >= {1'b0, count});
        end
    end

    always_comb
    begin
        first_pos = '0;
        for (int p = WORD_W - 1; p >= 0; p--)
        begin
            if (hit_vec[p])
            begin
                first_pos = POS_W'(p);
            end
        end
        res.hit   = |hit_vec;
        res.pos   = first_pos;
        res.carry = run[WORD_W-1][CNT_W] ? {CNT_W{1'b1}} : run[WORD_W-1][CNT_W-1:0];
    end

endmodule

`default_nettype wire

// ===== src/ffba_blk_div.sv =====
// Divide of an address offset by the constant block size: reciprocal multiply.
// Depends on ffba_pkg.
`default_nettype none

module ffba_blk_div
    import ffba_pkg::*;
#(
    parameter int BLOCK_BYTES = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ADDR_W-1:0] dividend,
    output div_res_t               res
);

    // an in-range offset is below BLOCK_BYTES << CNT_W, so it fits in X_W bits
    localparam int LB  = $clog2(BLOCK_BYTES);
    localparam int X_W = LB + CNT_W;
    localparam int SH  = X_W + LB;
    localparam int M_W = X_W + 1;
    localparam int P_W = X_W + M_W;
    // reciprocal rounded up; the quotient is exact for every dividend below 2^X_W
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] LIM     = ADDR_W'(BLOCK_BYTES) << CNT_W;
    localparam logic [M_W-1:0]    RECIP_M = M_W'(RECIP);
    localparam logic [X_W-1:0]    BB_X    = X_W'(BLOCK_BYTES);

    logic              load_reg;
    logic              mul_reg;
    logic              done_reg;
    logic              range_reg;
    logic [ADDR_W-1:0] dvd_reg;
    logic [P_W-1:0]    prod_reg;
    logic [CNT_W-1:0]  quot_reg;
    logic [X_W-1:0]    back;

    // quotient times block size, for the alignment check
    assign back = X_W'(quot_reg) * BB_X;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            load_reg <= start;
            mul_reg  <= load_reg;
            done_reg <= mul_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
        end
        if (load_reg)
        begin
            range_reg <= dvd_reg < LIM;
            prod_reg  <= P_W'(dvd_reg[X_W-1:0]) * P_W'(RECIP_M);
        end
        if (mul_reg)
        begin
            quot_reg <= prod_reg[SH +: CNT_W];
        end
    end

    assign res.done     = done_reg;
    assign res.in_range = range_reg;
    assign res.exact    = dvd_reg[X_W-1:0] == back;
    assign res.quot     = quot_reg;

endmodule

`default_nettype wire

// ===== src/first_fit_block_bitmap_allocator.sv =====
// First-fit contiguous block allocator: control, configuration and result registers.
// Depends on ffba_pkg, ffba_map_mem, ffba_word_scan and ffba_blk_div.
`default_nettype none

// A request is taken when start is high and busy is low; its single result
// appears on status/alloc_address for exactly one cycle with done high and
// cannot be held off. The bitmap lives in one memory of 32-bit words with a
// registered read. After reset the block clears that memory, one word a cycle,
// with busy high; configuration writes are taken during that time.
// From accept to done:
//   allocate: scan reads one word a cycle, then marking rewrites one word a
//             cycle; a rejected count is answered without a scan.
//   free:     the offset is divided by the block size with a reciprocal multiply
//             (dvd_reg, prod_reg, quot_reg), then the words touched are rewritten;
//             an unaligned address or a run leaving the region is rejected after
//             the divide, a zero count or an address below base at once.
//   clear:    one word written a cycle.
//   unknown request code: rejected at once.
// At the default size an allocate scans at most 32 words.

module first_fit_block_bitmap_allocator
    import ffba_pkg::*;
#(
    parameter int MAP_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        func,
    input  wire logic [CNT_W-1:0]  block_count,
    input  wire logic [ADDR_W-1:0] free_address,
    output logic                   done,
    output logic [1:0]             status,
    output logic [ADDR_W-1:0]      alloc_address,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [ADDR_W-1:0] cfg_data
);

    localparam int MAP_WORDS = (MAP_BLOCKS + 31) / 32;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PROD_W    = CNT_W + $clog2(BLOCK_BYTES + 1);
    localparam logic [AW-1:0]  LAST_WORD = AW'(MAP_WORDS - 1);
    // largest usable block total; the configured block count is clamped to it
    localparam logic [CNT_W:0] MAP_CAP =
        (MAP_BLOCKS > 2047) ? (CNT_W+1)'(2047) : (CNT_W+1)'(MAP_BLOCKS);

    state_t              state_reg, state_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [CNT_W-1:0]    carry_reg, carry_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    first_blk_reg, first_blk_next;
    logic                set_reg, set_next;
    logic [PROD_W-1:0]   blk_offset;
    logic [ADDR_W-1:0]   base_reg;
    logic [CNT_W-1:0]    blocks_reg;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;

    logic                mem_we;
    logic [31:0]         mem_wdata;
    logic [31:0]         mem_rdata;
    logic [31:0]         rmw_mask;

    logic [CNT_W-1:0]    total;
    logic [CNT_W:0]      wbase;
    logic [CNT_W:0]      rem_bits;
    logic                scan_last;
    logic [5:0]          scan_limit;
    logic [CNT_W:0]      hit_start;
    logic [CNT_W:0]      run_end;
    logic [CNT_W:0]      blk_left;
    logic                div_start;
    scan_res_t           scan;
    div_res_t            div;

    // ---------------------------------------------------------------
    // storage and datapath units
    // ---------------------------------------------------------------
    ffba_map_mem #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cur_reg),
        .wdata (mem_wdata),
        .raddr (cur_next),      // data for cur_reg is ready while cur_reg holds it
        .rdata (mem_rdata)
    );

    ffba_word_scan u_scan (
        .word  (mem_rdata),
        .carry (carry_reg),
        .count (count_reg),
        .limit (scan_limit),
        .res   (scan)
    );

    ffba_blk_div #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (free_address - base_reg),
        .res      (div)
    );

    // ---------------------------------------------------------------
    // derived values
    // ---------------------------------------------------------------
    assign total = ({1'b0, blocks_reg} > MAP_CAP) ? MAP_CAP[CNT_W-1:0] : blocks_reg;

    // first block number of the current word; only words below the total
    // are scanned or marked, so this stays under 2048
    assign wbase      = (CNT_W+1)'(cur_reg) << 5;
    assign rem_bits   = {1'b0, total} - wbase;
    assign scan_last  = rem_bits <= (CNT_W+1)'(32);
    assign scan_limit = scan_last ? rem_bits[5:0] : 6'd32;
    assign hit_start  = wbase + (CNT_W+1)'(scan.pos) + (CNT_W+1)'(1) - {1'b0, count_reg};

    // run is [first_blk, run_end)
    assign run_end  = {1'b0, first_blk_reg} + {1'b0, count_reg};
    assign blk_left = {1'b0, total} - {1'b0, div.quot};

    // byte offset of the run inside the region
    assign blk_offset = PROD_W'(first_blk_reg) * PROD_W'(BLOCK_BYTES);

    always_comb
    begin
        for (int p = 0; p < 32; p++)
        begin
            rmw_mask[p] = (wbase + (CNT_W+1)'(p) >= {1'b0, first_blk_reg}) &&
                          (wbase + (CNT_W+1)'(p) < run_end);
        end
    end

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            cur_reg    <= '0;
            done_reg   <= 1'b0;
            base_reg   <= '0;
            blocks_reg <= CNT_W'(1024);
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BASE:   base_reg   <= cfg_data;
                    REG_BLOCKS: blocks_reg <= cfg_data[CNT_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg     <= carry_next;
        count_reg     <= count_next;
        first_blk_reg <= first_blk_next;
        set_reg       <= set_next;
        status_reg    <= status_next;
        addr_reg      <= addr_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        carry_next     = carry_reg;
        count_next     = count_reg;
        first_blk_next = first_blk_reg;
        set_next       = set_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        addr_next      = addr_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        div_start      = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
                if (cur_reg == LAST_WORD)
                begin
                    cur_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    count_next  = block_count;
                    status_next = STAT_REJECT;
                    addr_next   = '0;
                    case (func)
                        FN_ALLOC:
                        begin
                            if (block_count == '0 || block_count > total)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                cur_next   = '0;
                                carry_next = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        FN_FREE:
                        begin
                            if (block_count == '0 || free_address < base_reg)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        FN_CLEAR:
                        begin
                            cur_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // one word per cycle; the run length carries between words
            ST_SCAN:
            begin
                if (scan.hit)
                begin
                    first_blk_next = hit_start[CNT_W-1:0];
                    cur_next       = AW'(hit_start >> 5);
                    set_next       = 1'b1;
                    state_next     = ST_RMW;
                end
                else if (scan_last)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NO_SPACE;
                    addr_next   = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cur_next   = cur_reg + AW'(1);
                    carry_next = scan.carry;
                end
            end

            ST_DIV:
            begin
                if (div.done)
                begin
                    if (!div.in_range || !div.exact || div.quot >= total ||
                        {1'b0, count_reg} > blk_left)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_REJECT;
                        addr_next   = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        first_blk_next = div.quot;
                        cur_next       = AW'(div.quot >> 5);
                        set_next       = 1'b0;
                        state_next     = ST_RMW;
                    end
                end
            end

            // write back word cur_reg while the next word is read
            ST_RMW:
            begin
                mem_we    = 1'b1;
                mem_wdata = set_reg ? (mem_rdata | rmw_mask) : (mem_rdata & ~rmw_mask);
                if (((run_end - (CNT_W+1)'(1)) >> 5) == (CNT_W+1)'(cur_reg))
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    addr_next   = set_reg ? base_reg + ADDR_W'(blk_offset) : '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + AW'(1);
                end
            end

            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (cur_reg == LAST_WORD)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    addr_next   = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = state_reg != ST_IDLE;
    assign done          = done_reg;
    assign status        = status_reg;
    assign alloc_address = addr_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result without a request in flight");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted request neither worked on nor answered");

    a_addr_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STAT_OK |-> alloc_address == '0)
        else $error("address given with a failed request");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_RMW || state_reg == ST_CLEAR || state_reg == ST_INIT)
        else $error("map written outside a write phase");

endmodule

`default_nettype wire
